// ----- design/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Storage geometry.
  localparam int Entries   = 16;
  localparam int KeyBits   = 32;
  localparam int ValueBits = 32;
  localparam int IdxBits   = $clog2(Entries);
  localparam int AgeBits   = IdxBits;
  localparam int CountBits = $clog2(Entries + 1);

  // Capacity register.
  localparam int CapBits   = 5;
  localparam int CapReset  = 16;
  localparam int CmpBits   = (CapBits > CountBits) ? CapBits : CountBits;

  // Stream payload widths.
  localparam int InDataBits  = KeyBits + ValueBits;
  localparam int OutDataBits = ValueBits + KeyBits;
  localparam int OutUserBits = 2;

  // Operation selector.
  typedef enum logic {
    FuncInsert = 1'b0,
    FuncFind   = 1'b1
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;  // capture the accepted item
    logic lookup;   // register tag match, free slot and victim
    logic commit;   // update the entries and write the result register
  } lkvc_cmd_t;

endpackage

// ----- design/lkvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for the LRU cache: accept, look up, commit, and output handshake.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lkvc_pkg::lkvc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StLookup = 3'b010,
    StUpdate = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StLookup;
        end
      end
      StLookup: begin
        cmd_o.lookup = 1'b1;
        state_d      = StUpdate;
      end
      StUpdate: begin
        // The result register must be empty or emptying this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/lkvc_dp.sv -----
// ----------------------------------------------------------------------------
// lkvc_dp
// Datapath of the LRU cache: entry storage, tag match, victim and free slot
// selection, recency ages, capacity register and result register.
// ----------------------------------------------------------------------------
module lkvc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lkvc_pkg::lkvc_cmd_t                cmd_i,
  input  logic                               func_i,
  input  logic [lkvc_pkg::KeyBits-1:0]       key_i,
  input  logic [lkvc_pkg::ValueBits-1:0]     value_i,
  input  logic                               cfg_we_i,
  input  logic [lkvc_pkg::CapBits-1:0]       cfg_wdata_i,
  output logic                               ok_o,
  output logic [lkvc_pkg::ValueBits-1:0]     found_value_o,
  output logic                               evicted_o,
  output logic [lkvc_pkg::KeyBits-1:0]       evicted_key_o
);

  localparam int N = lkvc_pkg::Entries;

  // Captured item.
  lkvc_pkg::func_e                   func_q;
  logic [lkvc_pkg::KeyBits-1:0]      key_q;
  logic [lkvc_pkg::ValueBits-1:0]    value_q;

  // Entry storage.
  logic [lkvc_pkg::KeyBits-1:0]      entry_key_q   [N];
  logic [lkvc_pkg::ValueBits-1:0]    entry_value_q [N];
  logic [N-1:0]                      entry_valid_q, entry_valid_d;
  logic [lkvc_pkg::AgeBits-1:0]      entry_age_q   [N];
  logic [lkvc_pkg::AgeBits-1:0]      entry_age_d   [N];
  logic [lkvc_pkg::CountBits-1:0]    count_q, count_d;
  logic [lkvc_pkg::CapBits-1:0]      cap_q;

  // Lookup results.
  logic                              hit_q, full_q;
  logic [lkvc_pkg::IdxBits-1:0]      hit_idx_q, victim_idx_q, free_idx_q;
  logic [lkvc_pkg::AgeBits-1:0]      hit_age_q;

  // Result register.
  logic                              ok_q;
  logic [lkvc_pkg::ValueBits-1:0]    found_q;
  logic                              ev_q;
  logic [lkvc_pkg::KeyBits-1:0]      evkey_q;

  // Lookup logic.
  logic [N-1:0]                      hit_vec, victim_vec;
  logic [lkvc_pkg::IdxBits-1:0]      hit_idx, victim_idx, free_idx;
  logic                              hit_any;
  logic [lkvc_pkg::CmpBits-1:0]      eff_cap, count_ext;
  logic [lkvc_pkg::AgeBits-1:0]      oldest_age;

  always_comb begin
    // Capacity zero acts as one; anything above the entry count is clamped.
    if (cap_q == '0) begin
      eff_cap = lkvc_pkg::CmpBits'(1);
    end else if (lkvc_pkg::CmpBits'(cap_q) > lkvc_pkg::CmpBits'(N)) begin
      eff_cap = lkvc_pkg::CmpBits'(N);
    end else begin
      eff_cap = lkvc_pkg::CmpBits'(cap_q);
    end
    count_ext = lkvc_pkg::CmpBits'(count_q);

    // Ages of valid entries always form 0..count-1, so the LRU entry is the
    // one whose age equals count-1.
    oldest_age = lkvc_pkg::AgeBits'(count_q - lkvc_pkg::CountBits'(1));

    for (int i = 0; i < N; i++) begin
      hit_vec[i]    = entry_valid_q[i] && (entry_key_q[i] == key_q);
      victim_vec[i] = entry_valid_q[i] && (entry_age_q[i] == oldest_age);
    end

    hit_any    = |hit_vec;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = lkvc_pkg::IdxBits'(i);
      end
      if (victim_vec[i]) begin
        victim_idx = lkvc_pkg::IdxBits'(i);
      end
      if (!entry_valid_q[i]) begin
        free_idx = lkvc_pkg::IdxBits'(i);
      end
    end
  end

  // Commit logic.
  logic [lkvc_pkg::IdxBits-1:0] slot;
  logic                         do_insert, do_touch;

  always_comb begin
    slot          = full_q ? victim_idx_q : free_idx_q;
    do_insert     = cmd_i.commit && (func_q == lkvc_pkg::FuncInsert) && !hit_q;
    do_touch      = cmd_i.commit && (func_q == lkvc_pkg::FuncFind) && hit_q;
    entry_valid_d = entry_valid_q;
    count_d       = count_q;
    for (int i = 0; i < N; i++) begin
      entry_age_d[i] = entry_age_q[i];
    end

    if (do_touch) begin
      for (int i = 0; i < N; i++) begin
        if (lkvc_pkg::IdxBits'(i) == hit_idx_q) begin
          entry_age_d[i] = '0;
        end else if (entry_valid_q[i] && (entry_age_q[i] < hit_age_q)) begin
          entry_age_d[i] = entry_age_q[i] + lkvc_pkg::AgeBits'(1);
        end
      end
    end

    if (do_insert) begin
      for (int i = 0; i < N; i++) begin
        if (lkvc_pkg::IdxBits'(i) == slot) begin
          entry_age_d[i] = '0;
        end else if (entry_valid_q[i] && (entry_age_q[i] != '1)) begin
          entry_age_d[i] = entry_age_q[i] + lkvc_pkg::AgeBits'(1);
        end
      end
      entry_valid_d[slot] = 1'b1;
      if (!full_q) begin
        count_d = count_q + lkvc_pkg::CountBits'(1);
      end
    end
  end

  // Control-side state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      count_q       <= '0;
      cap_q         <= lkvc_pkg::CapBits'(lkvc_pkg::CapReset);
      for (int i = 0; i < N; i++) begin
        entry_age_q[i] <= '0;
      end
    end else begin
      entry_valid_q <= entry_valid_d;
      count_q       <= count_d;
      for (int i = 0; i < N; i++) begin
        entry_age_q[i] <= entry_age_d[i];
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q  <= lkvc_pkg::func_e'(func_i);
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (cmd_i.lookup) begin
      hit_q        <= hit_any;
      hit_idx_q    <= hit_idx;
      hit_age_q    <= entry_age_q[hit_idx];
      victim_idx_q <= victim_idx;
      free_idx_q   <= free_idx;
      full_q       <= (count_ext >= eff_cap);
    end
    if (do_insert) begin
      entry_key_q[slot]   <= key_q;
      entry_value_q[slot] <= value_q;
    end
    if (cmd_i.commit) begin
      if (func_q == lkvc_pkg::FuncFind) begin
        ok_q    <= hit_q;
        found_q <= hit_q ? entry_value_q[hit_idx_q] : '0;
        ev_q    <= 1'b0;
        evkey_q <= '0;
      end else begin
        ok_q    <= !hit_q;
        found_q <= '0;
        ev_q    <= !hit_q && full_q;
        evkey_q <= (!hit_q && full_q) ? entry_key_q[victim_idx_q] : '0;
      end
    end
  end

  assign ok_o          = ok_q;
  assign found_value_o = found_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evkey_q;

endmodule

// ----- design/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                     Item
//   s_axis    in         tuser: func; tdata: key, value              request
//   m_axis    out        tuser: ok, evicted; tdata: found, ev. key   response
//   cfg       in         cfg_wdata_i: capacity (write only)          register
//
// Each request passes through three steps: one to accept it, one to match
// the key against all entries and pick the free slot and the victim, one to
// update the entries and load the response register. The three-step
// sequencer accepts a new request only from its idle step, so a request is
// not taken before the last one is committed. A stalled response holds the
// block in its commit step, and no new request is accepted meanwhile.
// Reset clears all valid bits, ages and the entry count and sets the
// capacity to sixteen; key and value storage is not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lkvc_pkg::InDataBits-1:0]     s_axis_tdata,   // key, value
  input  logic [0:0]                          s_axis_tuser,   // func

  // Response stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lkvc_pkg::OutDataBits-1:0]    m_axis_tdata,   // found_value, evicted_key
  output logic [lkvc_pkg::OutUserBits-1:0]    m_axis_tuser,   // ok, evicted

  // Capacity register write port.
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CapBits-1:0]        cfg_wdata_i
);

  // Commands from the sequencer to the datapath.
  lkvc_pkg::lkvc_cmd_t cmd;

  logic                              ok;
  logic [lkvc_pkg::ValueBits-1:0]    found_value;
  logic                              evicted;
  logic [lkvc_pkg::KeyBits-1:0]      evicted_key;

  // The sequencer owns the handshakes and the response valid flag.
  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // The datapath holds the entries, the capacity and the response payload.
  lkvc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (s_axis_tuser[0]),
    .key_i         (s_axis_tdata[lkvc_pkg::KeyBits-1:0]),
    .value_i       (s_axis_tdata[lkvc_pkg::InDataBits-1:lkvc_pkg::KeyBits]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ok_o          (ok),
    .found_value_o (found_value),
    .evicted_o     (evicted),
    .evicted_key_o (evicted_key)
  );

  // Responses pack the found value in the low half and the evicted key above.
  assign m_axis_tdata = {evicted_key, found_value};
  assign m_axis_tuser = {evicted, ok};

endmodule

// ----- bench/tb_lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key/value cache.
// ----------------------------------------------------------------------------
//
// Requests go in on the slave stream and responses come back on the master
// stream. Each accepted request is run through a behavioral copy of the cache
// held in a scoreboard. The copy keeps its own slots, ages, entry count and
// capacity, and the expected response is queued. Every response is then
// checked field by field against the oldest queued one.
//
// The run starts with a short directed part. It covers the extreme keys and
// values, a duplicate insert, find hits and misses, and capacity zero set
// below the entry count. It then fills a full store and evicts from it.
// After that come random phases, one per capacity setting, including zero
// and settings above the slot count. Keys mostly come from a small pool so
// that hits, duplicates and evictions are frequent; the rest are fully
// random. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  localparam int MaxGap       = 14;
  localparam int HoldAt       = 200;   // response count where the long hold-off starts
  localparam int HoldCycles   = 400;
  localparam int IdleLimit    = 2000;  // cycles with no handshake on either side
  localparam int PhaseItems   = 128;
  localparam int PoolSize     = 40;
  localparam int ReportLimit  = 10;

  typedef struct packed {
    logic                 ok;
    logic [ValueBits-1:0] found_value;
    logic                 evicted;
    logic [KeyBits-1:0]   evicted_key;
  } lookup_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a behavioral copy of the cache and the queue of responses it
  // predicts.
  // --------------------------------------------------------------------------
  class lru_cache_scoreboard;
    logic [KeyBits-1:0]   slot_key[Entries];
    logic [ValueBits-1:0] slot_value[Entries];
    bit                   slot_valid[Entries];
    int                   slot_age[Entries];
    int                   stored_count;
    int                   capacity;
    lookup_result_t       expected_results[$];
    int                   fail_count;
    int                   mismatch_count;
    int                   n_inserts, n_finds, n_hits, n_evictions, n_duplicates;

    function new();
      foreach (slot_valid[i]) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_age[i]   = 0;
      end
      stored_count = 0;
      capacity     = CapReset;
    endfunction

    function void set_capacity(int value);
      capacity = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Works out the response to one accepted request and updates the copy.
    function void note_request(func_e func, logic [KeyBits-1:0] key,
                               logic [ValueBits-1:0] value);
      lookup_result_t res;
      int hit;
      int slot;
      int limit;
      int promoted_age;
      res = '0;
      hit = -1;
      for (int i = Entries - 1; i >= 0; i--)
        if (slot_valid[i] && slot_key[i] == key) hit = i;
      if (func == FuncFind) begin
        n_finds++;
        if (hit >= 0) begin
          n_hits++;
          res.ok          = 1'b1;
          res.found_value = slot_value[hit];
          // Entries more recent than the hit each grow one step older.
          promoted_age = slot_age[hit];
          for (int i = 0; i < Entries; i++)
            if (i != hit && slot_valid[i] && slot_age[i] < promoted_age) slot_age[i]++;
          slot_age[hit] = 0;
        end
      end else begin
        n_inserts++;
        if (hit >= 0) begin
          n_duplicates++;
        end else begin
          slot  = -1;
          limit = (capacity == 0) ? 1 : (capacity > Entries) ? Entries : capacity;
          if (stored_count >= limit) begin
            // Oldest valid entry, lowest slot on a tie.
            for (int i = 0; i < Entries; i++)
              if (slot_valid[i] && (slot < 0 || slot_age[i] > slot_age[slot])) slot = i;
            if (slot >= 0) begin
              n_evictions++;
              res.evicted     = 1'b1;
              res.evicted_key = slot_key[slot];
              slot_valid[slot] = 1'b0;
              stored_count--;
            end
          end
          if (slot < 0)
            for (int i = Entries - 1; i >= 0; i--)
              if (!slot_valid[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < Entries; i++)
              if (slot_valid[i] && slot_age[i] < 255) slot_age[i]++;
            slot_key[slot]   = key;
            slot_value[slot] = value;
            slot_valid[slot] = 1'b1;
            slot_age[slot]   = 0;
            stored_count++;
            res.ok = 1'b1;
          end
        end
      end
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, int index, logic [31:0] want,
                                logic [31:0] got);
      if (got !== want) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("response %0d: %s expected %h, got %h", index, name, want, got);
      end
    endfunction

    function void check_response(int index, logic ok, logic [ValueBits-1:0] found,
                                 logic evicted, logic [KeyBits-1:0] evicted_key);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("response %0d arrived with no request outstanding", index);
        return;
      end
      want = expected_results.pop_front();
      compare_field("ok", index, 32'(want.ok), 32'(ok));
      compare_field("found_value", index, want.found_value, found);
      compare_field("evicted", index, 32'(want.evicted), 32'(evicted));
      compare_field("evicted_key", index, want.evicted_key, evicted_key);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;   // key, value
  logic [0:0]             s_axis_tuser  = '0;   // func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;         // found_value, evicted_key
  logic [OutUserBits-1:0] m_axis_tuser;         // ok, evicted
  logic                   cfg_we_i      = 1'b0;
  logic [CapBits-1:0]     cfg_wdata_i   = '0;

  lru_key_value_cache_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lru_cache_scoreboard sb;
  logic [KeyBits-1:0]  key_pool[PoolSize];
  bit                  sender_calm;
  int                  idle_cycles;
  int                  n_settings;

  // --------------------------------------------------------------------------
  // Driver tasks. Each is entered and left at a rising edge; inputs change
  // only by nonblocking assignment at that edge.
  // --------------------------------------------------------------------------

  // Offers one request after a random gap and returns at the edge where it
  // is accepted. The valid stays high when the next request follows at once.
  task automatic send_request(func_e func, logic [KeyBits-1:0] key,
                              logic [ValueBits-1:0] value);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(func, key, value);
  endtask

  // The capacity is written only once every response has come back, so the
  // block sits idle with nothing in flight.
  task automatic write_capacity(int value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CapBits'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_capacity(value);
    n_settings++;
  endtask

  // One random phase: mostly keys from a pool a little larger than the
  // capacity in force, so that hits, duplicates and evictions all occur.
  task automatic run_phase(int cap_value);
    int pool_len;
    int limit;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    func_e func;
    write_capacity(cap_value);
    sender_calm = ($urandom_range(0, 2) == 0);
    limit    = (cap_value == 0) ? 1 : (cap_value > Entries) ? Entries : cap_value;
    pool_len = limit + $urandom_range(1, limit + 3);
    if (pool_len > PoolSize) pool_len = PoolSize;
    for (int n = 0; n < PhaseItems; n++) begin
      func  = ($urandom_range(0, 1) == 1) ? FuncFind : FuncInsert;
      key   = ($urandom_range(0, 9) == 0) ? KeyBits'($urandom)
                                          : key_pool[$urandom_range(0, pool_len - 1)];
      case ($urandom_range(0, 15))
        0:       value = '0;
        1:       value = '1;
        default: value = ValueBits'($urandom);
      endcase
      send_request(func, key, value);
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stalls, calm stretches, and one long hold-off
  // during which the sender keeps offering requests.
  // --------------------------------------------------------------------------
  initial begin
    int  stall;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, MaxGap);
      if (taken == HoldAt) stall = HoldCycles;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_response(taken, m_axis_tuser[0], m_axis_tdata[ValueBits-1:0],
                        m_axis_tuser[1], m_axis_tdata[OutDataBits-1:ValueBits]);
      taken++;
    end
  end

  // Watchdog: ends the run when neither stream has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles", IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int cap_list[12] = '{1, 16, 2, 5, 17, 8, 3, 12, 0, 4, 31, 7};
    sb          = new();
    idle_cycles = 0;
    n_settings  = 0;
    sender_calm = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = KeyBits'($urandom);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: extreme keys and values, a rejected duplicate, hits
    // and a miss.
    send_request(FuncInsert, '0, '1);
    send_request(FuncInsert, '1, '0);
    send_request(FuncInsert, '0, 32'h0000_1234);
    send_request(FuncFind, '0, 32'hdead_beef);
    send_request(FuncFind, '1, '0);
    send_request(FuncFind, 32'd5, '1);

    // Capacity zero behaves as one. With two entries stored, each insert
    // evicts a single entry and the count stays at two.
    write_capacity(0);
    send_request(FuncInsert, 32'd5, 32'h55);
    send_request(FuncFind, '0, '0);
    send_request(FuncInsert, 32'd6, 32'h66);

    // Capacity above the slot count: fill every slot, then evict the oldest.
    write_capacity(31);
    for (int k = 0; k < 14; k++)
      send_request(FuncInsert, KeyBits'(100 + k), ValueBits'($urandom));
    send_request(FuncInsert, 32'd200, 32'h200);
    send_request(FuncFind, 32'd6, '0);

    foreach (cap_list[p]) run_phase(cap_list[p]);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // Keep waiting so that any stray response would still be caught.
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests over %0d capacity settings: %0d inserts, %0d finds",
             sb.n_inserts + sb.n_finds, n_settings + 1, sb.n_inserts, sb.n_finds);
    $display("%0d find hits, %0d evictions, %0d rejected duplicate inserts, %0d mismatches",
             sb.n_hits, sb.n_evictions, sb.n_duplicates, sb.mismatch_count);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- lru_key_value_cache_top.f -----
design/lkvc_pkg.sv
design/lkvc_ctrl.sv
design/lkvc_dp.sv
design/lru_key_value_cache_top.sv
bench/tb_lru_key_value_cache_top.sv
